@@ sv/rwmw_pkg.sv @@
// Shared constants, types and the CORDIC arctangent table for the mode weight block.
// No dependencies.
package rwmw_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_MAX       = 24;
	localparam int PROD_W           = 37;
	localparam int MOD_STAGES       = PROD_W;
	localparam int DIV_STAGES       = 32;
	localparam int PH_LAT           = 1 + MOD_STAGES + 1 + DIV_STAGES;
	localparam int RATIO_STEPS      = 16;

	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [2:0] REG_PORT_WIDTH  = 3'd2;
	localparam logic [2:0] REG_PORT_HEIGHT = 3'd3;
	localparam logic [2:0] REG_MODE_M      = 3'd4;
	localparam logic [2:0] REG_MODE_N      = 3'd5;
	localparam logic [2:0] REG_MODE_TE     = 3'd6;

	typedef struct packed {
		logic [15:0] ratio_x;
		logic [15:0] ratio_y;
		logic        busy;
	} ratio_t;

	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] v;
		case (i)
			0:  v = 34'sd536870912;
			1:  v = 34'sd316933406;
			2:  v = 34'sd167458907;
			3:  v = 34'sd85004756;
			4:  v = 34'sd42667331;
			5:  v = 34'sd21354465;
			6:  v = 34'sd10679838;
			7:  v = 34'sd5340245;
			8:  v = 34'sd2670163;
			9:  v = 34'sd1335087;
			10: v = 34'sd667544;
			11: v = 34'sd333772;
			12: v = 34'sd166886;
			13: v = 34'sd83443;
			14: v = 34'sd41722;
			15: v = 34'sd20861;
			16: v = 34'sd10430;
			17: v = 34'sd5215;
			18: v = 34'sd2608;
			19: v = 34'sd1304;
			20: v = 34'sd652;
			21: v = 34'sd326;
			22: v = 34'sd163;
			23: v = 34'sd81;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/rwmw_phase.sv @@
// Phase pipeline: k*r mod 2*ext, then remainder * 2^31 / ext in binary turns.
// Depends on rwmw_pkg.
module rwmw_phase (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] rel,
	input  logic [3:0]         k,
	input  logic [30:0]        ext,
	output logic [31:0]        phase
);
	localparam int PW = rwmw_pkg::PROD_W;
	localparam int MS = rwmw_pkg::MOD_STAGES;
	localparam int DS = rwmw_pkg::DIV_STAGES;

	logic [30:0]        ext_f;
	logic [31:0]        dmod;
	logic signed [37:0] prod;
	logic [37:0]        prod_abs;

	logic [PW-1:0] mdig_s [0:MS];
	logic [31:0]   mrem_s [0:MS];
	logic          mneg_s [0:MS];
	logic [31:0]   fixed;
	logic [30:0]   dp_s   [0:DS];
	logic [31:0]   dq_s   [0:DS];
	logic          dlsb_s;

	assign ext_f    = (ext == '0) ? 31'd1 : ext;
	assign dmod     = {ext_f, 1'b0};
	assign prod     = $signed({1'b0, k}) * rel;
	assign prod_abs = prod[37] ? 38'(-prod) : 38'(prod);
	assign fixed    = (mneg_s[MS] && mrem_s[MS] != '0) ? dmod - mrem_s[MS] : mrem_s[MS];
	assign phase    = dq_s[DS];

	always_ff @(posedge clk) begin
		logic [32:0] p2;
		logic [31:0] d2;
		if (en) begin
			mdig_s[0] <= prod_abs[PW-1:0];
			mneg_s[0] <= prod[37];
			mrem_s[0] <= '0;
			for (int i = 0; i < MS; i++) begin
				p2 = {mrem_s[i], mdig_s[i][PW-1]};
				if (p2 >= {1'b0, dmod})
					p2 = p2 - {1'b0, dmod};
				mrem_s[i+1] <= p2[31:0];
				mdig_s[i+1] <= {mdig_s[i][PW-2:0], 1'b0};
				mneg_s[i+1] <= mneg_s[i];
			end
			dp_s[0] <= fixed[31:1];
			dlsb_s  <= fixed[0];
			dq_s[0] <= '0;
			for (int j = 0; j < DS; j++) begin
				d2 = {dp_s[j], (j == 0) ? dlsb_s : 1'b0};
				if (d2 >= {1'b0, ext_f}) begin
					d2 = d2 - {1'b0, ext_f};
					dq_s[j+1] <= {dq_s[j][30:0], 1'b1};
				end else begin
					dq_s[j+1] <= {dq_s[j][30:0], 1'b0};
				end
				dp_s[j+1] <= d2[30:0];
			end
		end
	end
endmodule

@@ sv/rwmw_cordic.sv @@
// Pipelined rotation CORDIC: sine and cosine of a binary-turn angle, Q3.30.
// Depends on rwmw_pkg.
module rwmw_cordic #(
	parameter int STEPS = rwmw_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        ang,
	output logic signed [32:0] sin_o,
	output logic signed [32:0] cos_o
);
	logic signed [32:0] x_s [0:STEPS];
	logic signed [32:0] y_s [0:STEPS];
	logic signed [33:0] z_s [0:STEPS];
	logic               flip_s [0:STEPS];
	logic [31:0]        folded;
	logic               flip;

	assign flip   = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
	assign folded = flip ? ang - 32'h8000_0000 : ang;
	assign sin_o  = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	assign cos_o  = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= rwmw_pkg::CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= 34'($signed(folded));
			flip_s[0] <= flip;
			for (int i = 0; i < STEPS; i++) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - rwmw_pkg::atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + rwmw_pkg::atan_turn(i);
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end
endmodule

@@ sv/rwmw_ratio.sv @@
// Sequential divider for the wave-number ratios, rerun after reset and every config write.
// Depends on rwmw_pkg.
module rwmw_ratio (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [3:0]        m,
	input  logic [3:0]        n,
	input  logic [30:0]       w,
	input  logic [30:0]       h,
	output rwmw_pkg::ratio_t  st
);
	logic [34:0] ax, ay, mx;
	logic [34:0] px_q, py_q, mx_q;
	logic [15:0] qx_q, qy_q;
	logic        bx_q, by_q, busy_q, pend_q;
	logic [4:0]  cnt_q;
	logic [35:0] px2, py2;
	logic        first;

	assign ax    = 35'(m * h);
	assign ay    = 35'(n * w);
	assign mx    = (ax > ay) ? ax : ay;
	assign first = (cnt_q == 5'(rwmw_pkg::RATIO_STEPS));
	assign px2   = {px_q, first ? bx_q : 1'b0};
	assign py2   = {py_q, first ? by_q : 1'b0};

	assign st.ratio_x = qx_q;
	assign st.ratio_y = qy_q;
	assign st.busy    = busy_q | pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b1;
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			pend_q <= 1'b1;
			busy_q <= 1'b0;
		end else if (pend_q) begin
			pend_q <= 1'b0;
			busy_q <= 1'b1;
			cnt_q  <= 5'(rwmw_pkg::RATIO_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && !start) begin
			px_q <= {1'b0, ax[34:1]};
			py_q <= {1'b0, ay[34:1]};
			bx_q <= ax[0];
			by_q <= ay[0];
			mx_q <= mx;
			qx_q <= '0;
			qy_q <= '0;
		end else if (busy_q) begin
			if (px2 >= {1'b0, mx_q}) begin
				px_q <= 35'(px2 - {1'b0, mx_q});
				qx_q <= {qx_q[14:0], 1'b1};
			end else begin
				px_q <= px2[34:0];
				qx_q <= {qx_q[14:0], 1'b0};
			end
			if (py2 >= {1'b0, mx_q}) begin
				py_q <= 35'(py2 - {1'b0, mx_q});
				qy_q <= {qy_q[14:0], 1'b1};
			end else begin
				py_q <= py2[34:0];
				qy_q <= {qy_q[14:0], 1'b0};
			end
		end
	end
endmodule

@@ sv/rect_waveguide_mode_weight.sv @@
// Top level of the rectangular waveguide mode weight block.
// Depends on rwmw_pkg, rwmw_ratio, rwmw_phase, rwmw_cordic.
//
// Input channel in_valid/in_stall carries one point (pos_x, pos_y) per beat,
// Q16.16. Output channel out_valid/out_stall carries weight_x, weight_y
// (Q1.15, saturated) and mode_error, one beat per input beat, in order.
// Configuration: cfg_we with cfg_index and cfg_data, taken at the clock edge.
// The pipeline has one product stage, 37 remainder
// stages, one fold, 32 quotient stages, 1 + CORDIC_STEPS CORDIC stages and
// three weight stages. Throughput is one beat per cycle while in_stall is low.
// After reset and after each config write, the ratio divider runs, and
// in_stall is high while it does.
// When out_stall is high with a result waiting, the whole pipeline holds
// and in_stall is raised; nothing is lost or repeated.
module rect_waveguide_mode_weight #(
	parameter int CORDIC_STEPS = rwmw_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] weight_x,
	output logic signed [15:0] weight_y,
	output logic               mode_error,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int LAT = rwmw_pkg::PH_LAT + 1 + CORDIC_STEPS + 3;

	logic signed [31:0] origin_x_q, origin_y_q;
	logic [30:0]        width_q, height_q;
	logic [3:0]         m_q, n_q;
	logic               te_q;

	rwmw_pkg::ratio_t   rat;
	logic               en;
	logic [LAT:1]       vld_s;
	logic [31:0]        phx, phy;
	logic signed [32:0] rx, ry, sx, cx, sy, cy;
	logic signed [65:0] px, py;
	logic signed [32:0] tx_s1, ty_s1;
	logic signed [49:0] qx, qy;
	logic signed [19:0] wx_s2, wy_s2, nx, ny;
	logic [15:0]        rsel_x, rsel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= 31'd65536;
			height_q   <= 31'd65536;
			m_q        <= 4'd1;
			n_q        <= 4'd0;
			te_q       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				rwmw_pkg::REG_ORIGIN_X:    origin_x_q <= cfg_data;
				rwmw_pkg::REG_ORIGIN_Y:    origin_y_q <= cfg_data;
				rwmw_pkg::REG_PORT_WIDTH:  width_q    <= cfg_data[30:0];
				rwmw_pkg::REG_PORT_HEIGHT: height_q   <= cfg_data[30:0];
				rwmw_pkg::REG_MODE_M:      m_q        <= cfg_data[3:0];
				rwmw_pkg::REG_MODE_N:      n_q        <= cfg_data[3:0];
				rwmw_pkg::REG_MODE_TE:     te_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rwmw_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.m      (m_q),
		.n      (n_q),
		.w      ((width_q == '0) ? 31'd1 : width_q),
		.h      ((height_q == '0) ? 31'd1 : height_q),
		.st     (rat)
	);

	assign en       = !(vld_s[LAT] && out_stall);
	assign in_stall = rat.busy || !en;
	assign rx       = 33'(pos_x) - 33'(origin_x_q);
	assign ry       = 33'(pos_y) - 33'(origin_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[LAT-1:1], in_valid && !in_stall};
	end

	rwmw_phase u_phase_x (
		.clk(clk), .en(en), .rel(rx), .k(m_q), .ext(width_q), .phase(phx)
	);
	rwmw_phase u_phase_y (
		.clk(clk), .en(en), .rel(ry), .k(n_q), .ext(height_q), .phase(phy)
	);
	rwmw_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_x (
		.clk(clk), .en(en), .ang(phx), .sin_o(sx), .cos_o(cx)
	);
	rwmw_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_y (
		.clk(clk), .en(en), .ang(phy), .sin_o(sy), .cos_o(cy)
	);

	assign px     = cx * sy;
	assign py     = sx * cy;
	assign rsel_x = te_q ? rat.ratio_y : rat.ratio_x;
	assign rsel_y = te_q ? rat.ratio_x : rat.ratio_y;
	assign qx     = $signed({1'b0, rsel_x}) * tx_s1;
	assign qy     = $signed({1'b0, rsel_y}) * ty_s1;
	assign nx     = te_q ? wx_s2 : -wx_s2;
	assign ny     = te_q ? wy_s2 : -wy_s2;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767)
			return 16'sh7fff;
		else if (v < -20'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	always_ff @(posedge clk) begin
		logic signed [65:0] rpx, rpy;
		logic signed [49:0] rqx, rqy;
		if (en) begin
			rpx   = (px + 66'sd536870912) >>> 30;
			rpy   = (py + 66'sd536870912) >>> 30;
			tx_s1 <= rpx[32:0];
			ty_s1 <= rpy[32:0];
			rqx   = (qx + 50'sd536870912) >>> 30;
			rqy   = (qy + 50'sd536870912) >>> 30;
			wx_s2 <= rqx[19:0];
			wy_s2 <= rqy[19:0];
			if (m_q == '0 && n_q == '0) begin
				weight_x   <= '0;
				weight_y   <= '0;
				mode_error <= 1'b1;
			end else begin
				weight_x   <= sat16(nx);
				weight_y   <= sat16(ny);
				mode_error <= 1'b0;
			end
		end
	end

	assign out_valid = vld_s[LAT];
endmodule

@@ sv/rwmw_checker.sv @@
// Port-level checks for the mode weight block, bound to the top level.
// Depends on rect_waveguide_mode_weight.
module rwmw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               in_stall,
	input logic               cfg_we,
	input logic signed [15:0] weight_x,
	input logic signed [15:0] weight_y,
	input logic               mode_error
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(weight_x) && $stable(weight_y))
		else $error("output beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_error |-> weight_x == 16'sd0 && weight_y == 16'sd0)
		else $error("mode error beat with nonzero weights");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken while ratios recompute");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");
endmodule

bind rect_waveguide_mode_weight rwmw_checker u_rwmw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.in_stall   (in_stall),
	.cfg_we     (cfg_we),
	.weight_x   (weight_x),
	.weight_y   (weight_y),
	.mode_error (mode_error)
);
